### design/public_holiday_date_check_core_macros.svh
// Assertion helpers for the holiday date check block.
// Each helper takes a label, the clock, the active-low reset, an antecedent
// and a consequent. They compile to nothing when SYNTH is defined.
`ifndef PUBLIC_HOLIDAY_DATE_CHECK_CORE_MACROS_SVH
`define PUBLIC_HOLIDAY_DATE_CHECK_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication
`define PHDC_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("phdc: assertion failed");

// Next-cycle implication
`define PHDC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("phdc: assertion failed");

`else

`define PHDC_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define PHDC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

### design/phdc_pkg.sv
package phdc_pkg;

  // Field widths
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 12;

  // Fixed holiday slots and configuration port
  localparam int FIXED_SLOTS = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = DAY_W + MON_W;

  typedef struct packed {
    logic [MON_W-1:0] month;
    logic [DAY_W-1:0] day;
  } hol_t;

  // Reciprocal multipliers for division by constants, exact over 12-bit years
  localparam logic [11:0] RECIP_19   = 12'd3450;   // >> 16
  localparam logic [12:0] RECIP_100  = 13'd5243;   // >> 19
  localparam logic [8:0]  RECIP_25   = 9'd328;     // >> 13
  localparam logic [9:0]  RECIP_30   = 10'd547;    // >> 14
  localparam logic [13:0] RECIP_7    = 14'd9363;   // >> 16

  // Months
  localparam logic [MON_W-1:0] MON_MAR = 4'd3;
  localparam logic [MON_W-1:0] MON_APR = 4'd4;
  localparam logic [MON_W-1:0] MON_MAY = 4'd5;
  localparam logic [MON_W-1:0] MON_JUN = 4'd6;

  // Offsets counted in days from the last day of February
  localparam logic [6:0] END_MAR = 7'd31;
  localparam logic [6:0] END_APR = 7'd61;
  localparam logic [6:0] END_MAY = 7'd92;

endpackage

### design/phdc_date_if.sv
interface phdc_date_if;
  logic                           valid;
  logic                           ready;
  logic [phdc_pkg::DAY_W-1:0]     day_of_month;
  logic [phdc_pkg::MON_W-1:0]     month_number;
  logic [phdc_pkg::YEAR_W-1:0]    year_number;

  modport source (output valid, day_of_month, month_number, year_number, input ready);
  modport sink   (input valid, day_of_month, month_number, year_number, output ready);
endinterface

### design/phdc_result_if.sv
interface phdc_result_if;
  logic valid;
  logic ready;
  logic is_holiday;

  modport source (output valid, is_holiday, input ready);
  modport sink   (input valid, is_holiday, output ready);
endinterface

### design/phdc_cfg_regs.sv
module phdc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [phdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [phdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output phdc_pkg::hol_t                   fixed_holiday [phdc_pkg::FIXED_SLOTS]
);
  import phdc_pkg::*;

  hol_t fixed_r [FIXED_SLOTS];

  // Register file: index decode, writes beyond the slot count fall away
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FIXED_SLOTS; k++) begin
        fixed_r[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      for (int k = 0; k < FIXED_SLOTS; k++) begin
        if (cfg_index == CFG_IDX_W'(k)) begin
          fixed_r[k] <= hol_t'(cfg_wdata);
        end
      end
    end
  end

  assign fixed_holiday = fixed_r;

endmodule

### design/public_holiday_date_check_core.sv
// Holiday check for one Gregorian date.
// in_date carries day, month and year with a valid/ready handshake; a
// transfer happens at a rising edge with both high. out_result carries one
// is_holiday bit per date, in order, under the same handshake.
// Holidays are Easter Monday, Ascension and up to eight fixed day/month
// dates written through the cfg_ port (index 0..7, bits 4:0 day, 8:5 month,
// zero disables a slot). Write configuration only while the block is empty.
// Each date is registered in s1_r through s6_r and then in hit_r, which drives
// out_result. One date is taken per cycle while out_result is not stalled;
// the work is split over seven stages, each with one or two constant
// multiplies and a few narrow adds and compares.
// Each stage has its own valid bit and moves on when the next stage is empty
// or moving, so a stall at out_result fills the bubbles first and only then
// drops in_date.ready; nothing is dropped or repeated.
// Synchronous reset (rst_n low) empties the pipeline and clears all fixed
// holiday slots.
`include "public_holiday_date_check_core_macros.svh"

module public_holiday_date_check_core (
  input  logic                             clk,
  input  logic                             rst_n,
  phdc_date_if.sink                        in_date,
  phdc_result_if.source                    out_result,
  input  logic                             cfg_wr_en,
  input  logic [phdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [phdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import phdc_pkg::*;

  localparam int NUM_ST = 7;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [7:0]        q19;
    logic [5:0]        cent;
  } st1_t;

  typedef struct packed {
    logic [DAY_W-1:0] day;
    logic [MON_W-1:0] month;
    logic [4:0]       g;
    logic [5:0]       cterm;
    logic [12:0]      yterm;
  } st2_t;

  typedef struct packed {
    logic [DAY_W-1:0] day;
    logic [MON_W-1:0] month;
    logic [4:0]       g;
    logic [8:0]       hs;
    logic [12:0]      yterm;
  } st3_t;

  typedef struct packed {
    logic [DAY_W-1:0] day;
    logic [MON_W-1:0] month;
    logic [4:0]       g;
    logic [8:0]       hs;
    logic [3:0]       hq;
    logic [12:0]      yterm;
  } st4_t;

  typedef struct packed {
    logic [DAY_W-1:0] day;
    logic [MON_W-1:0] month;
    logic [4:0]       i;
    logic [12:0]      jsum;
  } st5_t;

  typedef struct packed {
    logic [DAY_W-1:0] day;
    logic [MON_W-1:0] month;
    logic [4:0]       i;
    logic [12:0]      jsum;
    logic [9:0]       jq;
    logic             fixed_hit;
  } st6_t;

  hol_t fixed_holiday [FIXED_SLOTS];

  logic [NUM_ST-1:0] v_r;
  logic [NUM_ST-1:0] v_in;
  logic [NUM_ST-1:0] adv;

  st1_t s1_r, s1_nxt;
  st2_t s2_r, s2_nxt;
  st3_t s3_r, s3_nxt;
  st4_t s4_r, s4_nxt;
  st5_t s5_r, s5_nxt;
  st6_t s6_r, s6_nxt;
  logic hit_r, hit_nxt;

  logic [23:0] q19_prod;
  logic [24:0] cent_prod;
  logic [11:0] q19x19;
  logic [11:0] g_full;
  logic [4:0]  g2;
  logic [8:0]  c8p13;
  logic [17:0] t25_prod;
  logic [6:0]  cterm_full;
  logic [17:0] hq_prod;
  logic [8:0]  hq30;
  logic [8:0]  h_full;
  logic [4:0]  h5;
  logic        h_dec;
  logic [25:0] jq_prod;
  logic [12:0] jq7;
  logic [12:0] j_full;
  logic [2:0]  j7;
  logic [5:0]  e7;
  logic [6:0]  mon_off;
  logic [6:0]  asc_off;
  logic [6:0]  md_full;
  logic [MON_W-1:0] mm7;
  logic [6:0]  ad_full;
  logic [MON_W-1:0] am7;
  logic        fixed_any;

  // Fixed holiday slots
  phdc_cfg_regs u_cfg_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fixed_holiday (fixed_holiday)
  );

  // Stage flow control: a stage loads when empty or when its item moves on
  always_comb begin
    adv[NUM_ST-1] = !v_r[NUM_ST-1] || out_result.ready;
    for (int k = NUM_ST - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign v_in          = {v_r[NUM_ST-2:0], in_date.valid};
  assign in_date.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NUM_ST; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 1: year / 19 and century by reciprocal multiply
  always_comb begin
    q19_prod     = 24'(in_date.year_number) * 24'(RECIP_19);
    cent_prod    = 25'(in_date.year_number) * 25'(RECIP_100);
    s1_nxt.day   = in_date.day_of_month;
    s1_nxt.month = in_date.month_number;
    s1_nxt.year  = in_date.year_number;
    s1_nxt.q19   = q19_prod[23:16];
    s1_nxt.cent  = cent_prod[24:19];
  end

  // Stage 2: golden number, century correction, weekday base term
  always_comb begin
    q19x19     = 12'(s1_r.q19) * 12'd19;
    g_full     = s1_r.year - q19x19;
    g2         = g_full[4:0];
    c8p13      = {s1_r.cent, 3'b000} + 9'd13;
    t25_prod   = 18'(c8p13) * 18'(RECIP_25);
    cterm_full = 7'(s1_r.cent) - 7'(s1_r.cent[5:2]) - 7'(t25_prod[17:13]) + 7'd15;
    s2_nxt.day   = s1_r.day;
    s2_nxt.month = s1_r.month;
    s2_nxt.g     = g2;
    s2_nxt.cterm = cterm_full[5:0];
    s2_nxt.yterm = 13'(s1_r.year) + 13'(s1_r.year[11:2]) + 13'd2
                   - 13'(s1_r.cent) + 13'(s1_r.cent[5:2]);
  end

  // Stage 3: epact sum before reduction
  always_comb begin
    s3_nxt.day   = s2_r.day;
    s3_nxt.month = s2_r.month;
    s3_nxt.g     = s2_r.g;
    s3_nxt.hs    = 9'(s2_r.cterm) + 9'(s2_r.g) * 9'd19;
    s3_nxt.yterm = s2_r.yterm;
  end

  // Stage 4: quotient of the sum by 30
  always_comb begin
    hq_prod      = 18'(s3_r.hs) * 18'(RECIP_30);
    s4_nxt.day   = s3_r.day;
    s4_nxt.month = s3_r.month;
    s4_nxt.g     = s3_r.g;
    s4_nxt.hs    = s3_r.hs;
    s4_nxt.hq    = hq_prod[17:14];
    s4_nxt.yterm = s3_r.yterm;
  end

  // Stage 5: h mod 30, Oudin's correction to i, weekday sum
  always_comb begin
    hq30   = 9'(s4_r.hq) * 9'd30;
    h_full = s4_r.hs - hq30;
    h5     = h_full[4:0];
    // h of 29, or 28 with a late golden number, steps back one day
    h_dec  = (h5 == 5'd29) || ((h5 == 5'd28) && (s4_r.g > 5'd10));
    s5_nxt.day   = s4_r.day;
    s5_nxt.month = s4_r.month;
    s5_nxt.i     = h5 - 5'(h_dec);
    s5_nxt.jsum  = s4_r.yterm + 13'(s5_nxt.i);
  end

  // Stage 6: weekday quotient, fixed holiday match
  always_comb begin
    jq_prod   = 26'(s5_r.jsum) * 26'(RECIP_7);
    fixed_any = 1'b0;
    for (int k = 0; k < FIXED_SLOTS; k++) begin
      if ((fixed_holiday[k] != '0) && (fixed_holiday[k].day == s5_r.day)
          && (fixed_holiday[k].month == s5_r.month)) begin
        fixed_any = 1'b1;
      end
    end
    s6_nxt.day       = s5_r.day;
    s6_nxt.month     = s5_r.month;
    s6_nxt.i         = s5_r.i;
    s6_nxt.jsum      = s5_r.jsum;
    s6_nxt.jq        = jq_prod[25:16];
    s6_nxt.fixed_hit = fixed_any;
  end

  // Stage 7: Easter as a day offset from end of February, then the two
  // movable feasts turned back into day and month
  always_comb begin
    jq7     = 13'(s6_r.jq) * 13'd7;
    j_full  = s6_r.jsum - jq7;
    j7      = j_full[2:0];
    e7      = 6'(s6_r.i) + 6'd28 - 6'(j7);
    mon_off = 7'(e7) + 7'd1;
    asc_off = 7'(e7) + 7'd39;

    // Easter Monday
    if (mon_off <= END_MAR) begin
      md_full = mon_off;
      mm7     = MON_MAR;
    end else begin
      md_full = mon_off - END_MAR;
      mm7     = MON_APR;
    end

    // Ascension: never earlier than the last day of April
    if (asc_off <= END_APR) begin
      ad_full = asc_off - END_MAR;
      am7     = MON_APR;
    end else if (asc_off <= END_MAY) begin
      ad_full = asc_off - END_APR;
      am7     = MON_MAY;
    end else begin
      ad_full = asc_off - END_MAY;
      am7     = MON_JUN;
    end

    hit_nxt = s6_r.fixed_hit
              || ((s6_r.day == md_full[4:0]) && (s6_r.month == mm7))
              || ((s6_r.day == ad_full[4:0]) && (s6_r.month == am7));
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_r <= s1_nxt;
    end
    if (adv[1]) begin
      s2_r <= s2_nxt;
    end
    if (adv[2]) begin
      s3_r <= s3_nxt;
    end
    if (adv[3]) begin
      s4_r <= s4_nxt;
    end
    if (adv[4]) begin
      s5_r <= s5_nxt;
    end
    if (adv[5]) begin
      s6_r <= s6_nxt;
    end
    if (adv[6]) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_result.valid      = v_r[NUM_ST-1];
  assign out_result.is_holiday = hit_r;

  // Checks
  `PHDC_ASSERT_IMPL(a_ready_when_out_empty, clk, rst_n, !v_r[NUM_ST-1], in_date.ready)
  `PHDC_ASSERT_IMPL(a_golden_range, clk, rst_n, v_r[0], g2 < 5'd19)
  `PHDC_ASSERT_IMPL(a_epact_range, clk, rst_n, v_r[3], h5 < 5'd30)
  `PHDC_ASSERT_IMPL(a_easter_range, clk, rst_n, v_r[5], (e7 >= 6'd22) && (e7 <= 6'd56))
  `PHDC_ASSERT_NEXT(a_held_item_kept, clk, rst_n, v_r[4] && !adv[4], v_r[4])

endmodule

### bench/tb_top.sv
module tb_top;
  import phdc_pkg::*;

  localparam int PIPE_LATENCY = 7;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  phdc_date_if   date_ch();
  phdc_result_if res_ch();

  public_holiday_date_check_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_date    (date_ch),
    .out_result (res_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Local copy of the fixed holiday slots, and the values for the next load
  hol_t fixed_slot [FIXED_SLOTS];
  hol_t next_slot  [FIXED_SLOTS];

  bit holiday_queue [$];
  int fail_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int holdoff_req;
  int holdoff_left;

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Easter Monday and Ascension for one year (Oudin)
  function automatic void feast_dates(input int unsigned yr,
                                      output int unsigned mon_day, mon_mon,
                                      output int unsigned asc_day, asc_mon);
    int unsigned g, c, h, q, i, j, em, ed, k;
    int l;
    g = yr % 19;
    c = yr / 100;
    h = (c - c / 4 - (8 * c + 13) / 25 + 19 * g + 15) % 30;
    q = h / 28;
    i = h - q * (1 - q * (29 / (h + 1)) * ((21 - g) / 11));
    j = (yr + yr / 4 + i + 2 - c + c / 4) % 7;
    l = int'(i) - int'(j);
    em = 3 + (l + 40) / 44;
    ed = l + 28 - 31 * int'(em / 4);
    // Monday after Easter, may roll into April
    mon_day = ed + 1;
    mon_mon = em;
    if (mon_day > ((mon_mon == 4) ? 30 : 31)) begin
      mon_day -= (mon_mon == 4) ? 30 : 31;
      mon_mon++;
    end
    // Easter plus 39 days across March, April and May
    asc_day = ed + 39;
    asc_mon = em;
    for (k = 0; k < 3 && asc_day > ((asc_mon == 4) ? 30 : 31); k++) begin
      asc_day -= (asc_mon == 4) ? 30 : 31;
      asc_mon++;
    end
  endfunction

  function automatic bit holiday_expected(logic [DAY_W-1:0] d, logic [MON_W-1:0] m,
                                          logic [YEAR_W-1:0] y);
    int unsigned md, mm, ad, am;
    feast_dates(y, md, mm, ad, am);
    if (d == md && m == mm) return 1'b1;
    if (d == ad && m == am) return 1'b1;
    for (int k = 0; k < FIXED_SLOTS; k++) begin
      if (fixed_slot[k] != '0 && fixed_slot[k].day == d && fixed_slot[k].month == m)
        return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_failure(string what);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("ERROR @%0d: %s", cycle_count, what);
  endtask

  // Predict on every input transfer, check every result transfer
  always @(posedge clk) begin : check_results
    bit want;
    if (rst_n) begin
      if (date_ch.valid && date_ch.ready)
        holiday_queue.push_back(holiday_expected(date_ch.day_of_month,
                                                 date_ch.month_number,
                                                 date_ch.year_number));
      if (res_ch.valid && res_ch.ready) begin
        if (holiday_queue.size() == 0) begin
          report_failure($sformatf("result %0b with none expected", res_ch.is_holiday));
        end else begin
          want = holiday_queue.pop_front();
          if (res_ch.is_holiday !== want)
            report_failure($sformatf("is_holiday expected %0b, got %0b",
                                     want, res_ch.is_holiday));
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off counted here
  always @(posedge clk) begin
    if (holdoff_req != 0) begin
      holdoff_left = holdoff_req;
      holdoff_req  = 0;
    end
    if (holdoff_left != 0) begin
      res_ch.ready <= 1'b0;
      holdoff_left--;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // One date; returns at the edge of its transfer with valid still high
  task automatic send_date(logic [DAY_W-1:0] d, logic [MON_W-1:0] m, logic [YEAR_W-1:0] y);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      date_ch.valid <= 1'b0;
      @(posedge clk);
    end
    date_ch.valid        <= 1'b1;
    date_ch.day_of_month <= d;
    date_ch.month_number <= m;
    date_ch.year_number  <= y;
    do @(posedge clk); while (!date_ch.ready);
  endtask

  task automatic stop_sending();
    date_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (holiday_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic program_slots();
    for (int k = 0; k < FIXED_SLOTS; k++) begin
      cfg_wr_en     <= 1'b1;
      cfg_index     <= CFG_IDX_W'(k);
      cfg_wdata     <= next_slot[k];
      fixed_slot[k]  = next_slot[k];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly dates near the feasts or on a slot, some pure noise
  task automatic send_random_date();
    logic [DAY_W-1:0]  d;
    logic [MON_W-1:0]  m;
    logic [YEAR_W-1:0] y;
    int unsigned md, mm, ad, am;
    int pick;
    hol_t s;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 19))
      0:       y = YEAR_W'($urandom_range(0, 1582));
      1:       y = {YEAR_W{1'b1}};
      default: y = YEAR_W'($urandom_range(1583, 4095));
    endcase
    feast_dates(y, md, mm, ad, am);
    if (pick < 25) begin
      d = md[DAY_W-1:0];
      m = mm[MON_W-1:0];
    end else if (pick < 50) begin
      d = ad[DAY_W-1:0];
      m = am[MON_W-1:0];
    end else if (pick < 62) begin
      // a day either side of one of the feasts
      d = ($urandom_range(0, 1) ? md[DAY_W-1:0] : ad[DAY_W-1:0]);
      m = (d == md[DAY_W-1:0]) ? mm[MON_W-1:0] : am[MON_W-1:0];
      d = $urandom_range(0, 1) ? d + 1'b1 : d - 1'b1;
    end else if (pick < 78) begin
      s = fixed_slot[$urandom_range(0, FIXED_SLOTS - 1)];
      d = s.day;
      m = s.month;
    end else begin
      d = DAY_W'($urandom_range(0, 31));
      m = MON_W'($urandom_range(0, 15));
    end
    send_date(d, m, y);
  endtask

  // Feast days, Easter Sunday and invalid dates with all slots cleared, incl. Easter Monday on April 1
  task automatic test_feast_dates();
    int unsigned md, mm, ad, am;
    int unsigned yrs [3] = '{0, 1582, 4095};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_date(5'd1,  MON_APR, 12'd2024);
    send_date(5'd31, MON_MAR, 12'd2024);
    send_date(5'd9,  MON_MAY, 12'd2024);
    send_date(5'd22, MON_APR, 12'd2019);
    send_date(5'd30, MON_MAY, 12'd2019);
    send_date(5'd26, MON_APR, 12'd2038);
    send_date(5'd3,  MON_JUN, 12'd2038);
    send_date(5'd23, MON_MAR, 12'd2285);
    send_date(5'd30, MON_APR, 12'd2285);
    foreach (yrs[n]) begin
      feast_dates(yrs[n], md, mm, ad, am);
      send_date(md[DAY_W-1:0], mm[MON_W-1:0], yrs[n][YEAR_W-1:0]);
      send_date(ad[DAY_W-1:0], am[MON_W-1:0], yrs[n][YEAR_W-1:0]);
    end
    send_date('0, '0, '0);
    send_date('1, '1, '1);
    send_date(5'd31, MON_APR, 12'd2024);
    stop_sending();
    wait_drained();
  endtask

  // Slot edge cases: all ones, day only, month only, ordinary dates
  task automatic test_fixed_slots();
    next_slot[0] = 9'h1FF;
    next_slot[1] = '{month: 4'd0,  day: 5'd1};
    next_slot[2] = '{month: 4'd1,  day: 5'd0};
    next_slot[3] = '{month: 4'd12, day: 5'd25};
    next_slot[4] = '0;
    next_slot[5] = '0;
    next_slot[6] = '0;
    next_slot[7] = '{month: 4'd7,  day: 5'd14};
    program_slots();
    send_date(5'd31, 4'd15, 12'd0);
    send_date(5'd1,  4'd0,  12'd1583);
    send_date(5'd0,  4'd1,  12'd2000);
    send_date(5'd25, 4'd12, 12'd2023);
    send_date(5'd14, 4'd7,  12'd4095);
    send_date(5'd0,  4'd0,  12'd2000);
    send_date(5'd24, 4'd12, 12'd2023);
    send_date(5'd1,  4'd1,  12'd2000);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      // one pause mid-phase until everything has come back
      if (n == count / 2) begin
        stop_sending();
        wait_drained();
      end
      send_random_date();
    end
    stop_sending();
    wait_drained();
  endtask

  // Receiver held off while dates keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_req    = 200;
    repeat (60) send_random_date();
    stop_sending();
    wait_drained();
  endtask

  initial begin
    date_ch.valid        <= 1'b0;
    date_ch.day_of_month <= '0;
    date_ch.month_number <= '0;
    date_ch.year_number  <= '0;
    cfg_wr_en            <= 1'b0;
    cfg_index            <= '0;
    cfg_wdata            <= '0;
    rst_n                <= 1'b0;
    fail_count     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_req    = 0;
    holdoff_left   = 0;
    foreach (fixed_slot[k]) fixed_slot[k] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_feast_dates();
    test_fixed_slots();

    // Common fixed holidays, no idling
    next_slot[0] = '{month: 4'd1,  day: 5'd1};
    next_slot[1] = '{month: 4'd5,  day: 5'd1};
    next_slot[2] = '{month: 4'd5,  day: 5'd8};
    next_slot[3] = '{month: 4'd7,  day: 5'd14};
    next_slot[4] = '{month: 4'd8,  day: 5'd15};
    next_slot[5] = '{month: 4'd11, day: 5'd1};
    next_slot[6] = '{month: 4'd11, day: 5'd11};
    next_slot[7] = '{month: 4'd12, day: 5'd25};
    program_slots();
    test_random_traffic(0, 0, 400);

    // Every slot at all ones, sender mostly idle
    foreach (next_slot[k]) next_slot[k] = 9'h1FF;
    program_slots();
    test_random_traffic(83, 0, 400);

    // Random slot values, receiver mostly stalling
    foreach (next_slot[k]) next_slot[k] = hol_t'(CFG_DATA_W'($urandom_range(0, 511)));
    program_slots();
    test_random_traffic(0, 83, 400);
    test_backpressure();

    // Half the slots unused, the rest day-only or month-only
    foreach (next_slot[k]) begin
      if (k < 4) next_slot[k] = '0;
      else if (k % 2 == 0) next_slot[k] = '{month: 4'd0, day: 5'($urandom_range(1, 31))};
      else next_slot[k] = '{month: 4'($urandom_range(1, 15)), day: 5'd0};
    end
    program_slots();
    test_random_traffic(8, 8, 400);

    repeat (PIPE_LATENCY * 4) @(posedge clk);
    if (holiday_queue.size() != 0) report_failure("results still outstanding at end");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/phdc_pkg.sv
design/phdc_date_if.sv
design/phdc_result_if.sv
design/phdc_cfg_regs.sv
design/public_holiday_date_check_core.sv
bench/tb_top.sv
